// ----- hw/rtl/fpd_pkg.sv -----
// Shared constants and types for the framed packet deframer.
`default_nettype none
package fpd_pkg;

    localparam int MAX_PAYLOAD = 28;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] START_MARKER_RST = 8'h02;
    localparam logic [7:0] END_MARKER_RST   = 8'h03;

    // configuration register indexes
    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    // frame phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_CHECK = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;

    // status codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_CHECKSUM = 2'd1;
    localparam logic [1:0] ERR_END      = 2'd2;
    localparam logic [1:0] ERR_LENGTH   = 2'd3;

    typedef struct packed {
        logic [1:0] frame_error;
        logic       is_status;
        logic [7:0] payload_byte;
    } fpd_result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fpd_parser.sv -----
// Frame parser: marker registers, phase tracking, checksum and status decode.
`default_nettype none
module fpd_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                fire,
    input  wire logic [7:0]          rx_byte,
    output logic                     res_valid,
    output fpd_pkg::fpd_result_t     res
);
    import fpd_pkg::*;

    logic [7:0]       start_marker_reg;
    logic [7:0]       end_marker_reg;
    logic [2:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]       xor_reg, xor_next;
    logic             matched_reg, matched_next;
    logic [LEN_W-1:0] left_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_START_MARKER) begin
                start_marker_reg <= cfg_data;
            end else begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    assign left_dec = bytes_left_reg - LEN_W'(1);

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        matched_next    = matched_reg;
        res_valid       = 1'b0;
        res             = '0;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == start_marker_reg) begin
                    phase_next      = PH_LEN;
                    xor_next        = 8'd0;
                    matched_next    = 1'b0;
                    bytes_left_next = '0;
                end
            end
            PH_LEN: begin
                if (rx_byte > 8'(MAX_PAYLOAD)) begin
                    phase_next       = PH_HUNT;
                    bytes_left_next  = '0;
                    res_valid        = 1'b1;
                    res.is_status    = 1'b1;
                    res.frame_error  = ERR_LENGTH;
                end else begin
                    bytes_left_next = rx_byte[LEN_W-1:0];
                    xor_next        = 8'd0;
                    phase_next      = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                xor_next         = xor_reg ^ rx_byte;
                bytes_left_next  = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHECK;
                end
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
            end
            PH_CHECK: begin
                matched_next = (rx_byte == xor_reg);
                phase_next   = PH_END;
            end
            PH_END: begin
                phase_next    = PH_HUNT;
                res_valid     = 1'b1;
                res.is_status = 1'b1;
                if (!matched_reg) begin
                    res.frame_error = ERR_CHECKSUM;
                end else if (rx_byte != end_marker_reg) begin
                    res.frame_error = ERR_END;
                end else begin
                    res.frame_error = ERR_OK;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            xor_reg        <= 8'd0;
            matched_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            matched_reg    <= matched_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/fpd_out_reg.sv -----
// Result register toward the output stream.
`default_nettype none
module fpd_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire fpd_pkg::fpd_result_t res,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,
    output logic [2:0]               m_tuser
);
    import fpd_pkg::*;

    logic        valid_reg;
    fpd_result_t res_reg;

    // a held item leaves when taken, so a new one may load the same cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tuser  = {res_reg.frame_error, res_reg.is_status};

endmodule
`default_nettype wire

// ----- hw/rtl/framed_packet_deframer_xor_check_core.sv -----
// Top level: input register, frame parser and result register.
// A payload byte or status passes the input register, then the result register, before it shows on m_tvalid.
// Throughput: one byte per cycle; the input register holds only while the result register
// holds an item that m_tready has not taken.
// Reset: synchronous, active-low aresetn clears both registers' valid flags, puts the parser
// back to hunting and loads the start and end markers with 0x02 and 0x03.
`default_nettype none
module framed_packet_deframer_xor_check_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] payload_byte
    output logic [2:0]      m_tuser,   // [0] is_status, [2:1] frame_error
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import fpd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_free;
    logic        fire;
    logic        res_valid;
    fpd_result_t res;

    assign cfg_ready = 1'b1;

    // process the held byte once the result register can take its item
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    fpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fpd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/fpd_checker.sv -----
// Port-level checks on the deframer, bound to the top level.
`default_nettype none
module fpd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser
);
    import fpd_pkg::*;

    // payload items carry no error code
    a_payload_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == ERR_OK)
        else $error("payload item with nonzero frame_error");

    // status items carry a zero data byte
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("status item with nonzero data");

    // a stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    // nothing leaves right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind framed_packet_deframer_xor_check_core fpd_checker u_fpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
